### design/icmp_erc_pkg.sv
package icmp_erc_pkg;

    localparam int STAMP_SLOTS = 64;
    localparam int SLOT_W      = $clog2(STAMP_SLOTS);
    localparam int ADDR_W      = SLOT_W + 1;
    localparam int STAMP_W     = 64;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 32;

    localparam logic [1:0] VERDICT_VALID   = 2'd0;
    localparam logic [1:0] VERDICT_OWN_REQ = 2'd1;
    localparam logic [1:0] VERDICT_OTHER   = 2'd2;
    localparam logic [1:0] VERDICT_INVALID = 2'd3;

    localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] FILL_BYTE         = 8'h61;
    localparam logic [7:0] PROTO_ICMP        = 8'd1;
    localparam logic [3:0] IP_VERSION        = 4'd4;
    localparam logic [3:0] IHL_MIN           = 4'd5;
    localparam logic [5:0] MIN_HDR_BYTES     = 6'd20;

    localparam logic CFG_IDENT   = 1'b0;
    localparam logic CFG_HIGHEST = 1'b1;

    typedef struct packed {
        logic               is_stamp;
        logic [7:0]         data;
        logic               last;
        logic [5:0]         slot;
        logic               half;
        logic [STAMP_W-1:0] word;
    } item_t;

    function automatic logic [15:0] csum_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[16] ? (t[15:0] + 16'd1) : t[15:0];
    endfunction

endpackage

### design/icmp_erc_ram.sv
module icmp_erc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

### design/icmp_erc_front.sv
module icmp_erc_front
    import icmp_erc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_TDATA_W-1:0] in_data,
    input  logic                  in_user,
    input  logic                  in_last,
    input  logic                  pop,
    output logic                  head_valid,
    output item_t                 head
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, do_pop;
    item_t      item;

    always_comb
    begin
        item.is_stamp = in_user;
        item.data     = in_data[7:0];
        item.last     = in_last;
        item.slot     = in_data[13:8];
        item.half     = in_data[14];
        item.word     = in_data[78:15];
    end

    assign in_ready   = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/icmp_erc_back.sv
module icmp_erc_back
    import icmp_erc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  item_t                  head,
    output logic                   pop,
    input  logic [15:0]            expected_ident,
    input  logic [15:0]            highest_sequence,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data
);

    // stage A packet state
    logic [15:0] count_reg, count_next;
    logic [3:0]  hw_reg, hw_next;
    logic [15:0] tl_reg, tl_next;
    logic        hf_reg, hf_next;
    logic [15:0] kc_reg, kc_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] csum_reg, csum_next;
    logic [7:0]  pend_reg, pend_next;

    logic        a_take, is_byte, overflow;
    logic [5:0]  hl;
    logic [15:0] off, p;
    logic [16:0] cc, icmp_len;
    logic [15:0] csum_f;
    logic        chk_stamp, chk_fill;
    logic [7:0]  b;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [STAMP_W-1:0] ram_rdata;

    // stage B
    logic        b_valid_reg, b_last_reg, b_stamp_reg, b_fill_reg;
    logic [7:0]  b_byte_reg;
    logic [2:0]  b_sel_reg;
    logic        b_bad_reg, b_short_reg, b_csum_ok_reg, b_has_kind_reg, b_has_seq_reg;
    logic [15:0] b_kc_reg, b_id_reg, b_seq_reg;
    logic        pf_reg;
    logic        b_advance, mismatch, pf_all, load_out;
    logic [7:0]  stamp_byte;
    logic [1:0]  verdict;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    assign b_advance = !b_valid_reg || !b_last_reg || !out_valid_reg || out_ready;
    assign a_take    = b_advance;
    assign pop       = head_valid && a_take;
    assign is_byte   = pop && !head.is_stamp;
    assign b         = head.data;
    assign overflow  = (count_reg == 16'hFFFF);

    always_comb
    begin
        count_next = count_reg;
        hw_next    = hw_reg;
        tl_next    = tl_reg;
        hf_next    = hf_reg;
        kc_next    = kc_reg;
        id_next    = id_reg;
        seq_next   = seq_reg;
        csum_next  = csum_reg;
        pend_next  = pend_reg;
        chk_stamp  = 1'b0;
        chk_fill   = 1'b0;
        off        = 16'd0;
        p          = 16'd0;
        hl         = MIN_HDR_BYTES;
        if (is_byte)
        begin
            if (overflow)
            begin
                hf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 16'd1;
                case (count_reg)
                    16'd0:
                    begin
                        hw_next = b[3:0];
                        if (b[7:4] != IP_VERSION || b[3:0] < IHL_MIN)
                        begin
                            hf_next = 1'b1;
                        end
                    end
                    16'd2: tl_next[15:8] = b;
                    16'd3: tl_next[7:0]  = b;
                    16'd9:
                    begin
                        if (b != PROTO_ICMP)
                        begin
                            hf_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        hl = (hw_next < IHL_MIN) ? MIN_HDR_BYTES : {hw_next, 2'b00};
        if (is_byte && !overflow && count_reg >= {10'd0, hl})
        begin
            off     = count_reg - {10'd0, hl};
            p       = off - 16'd8;
            if (!off[0])
            begin
                pend_next = b;
            end
            else
            begin
                csum_next = csum_add(csum_reg, {pend_reg, b});
                pend_next = 8'd0;
            end
            case (off)
                16'd0: kc_next[15:8]  = b;
                16'd1: kc_next[7:0]   = b;
                16'd4: id_next[15:8]  = b;
                16'd5: id_next[7:0]   = b;
                16'd6: seq_next[15:8] = b;
                16'd7: seq_next[7:0]  = b;
                default:
                begin
                    if (off >= 16'd8)
                    begin
                        chk_stamp = (p < 16'd16);
                        chk_fill  = (p >= 16'd16);
                    end
                end
            endcase
        end
        cc       = {1'b0, count_reg} + 17'd1;
        icmp_len = (cc > {11'd0, hl}) ? (cc - {11'd0, hl}) : 17'd0;
        csum_f   = icmp_len[0] ? csum_add(csum_next, {pend_next, 8'd0}) : csum_next;
    end

    assign ram_we   = pop && head.is_stamp;
    assign ram_re   = chk_stamp;
    assign ram_addr = head.is_stamp ? {head.slot[SLOT_W-1:0], head.half}
                                    : {seq_reg[SLOT_W-1:0], p[3]};

    icmp_erc_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (2 * STAMP_SLOTS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (head.word),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 16'd0;
            hw_reg    <= 4'd0;
            tl_reg    <= 16'd0;
            hf_reg    <= 1'b0;
            kc_reg    <= 16'd0;
            id_reg    <= 16'd0;
            seq_reg   <= 16'd0;
            csum_reg  <= 16'd0;
            pend_reg  <= 8'd0;
        end
        else if (is_byte && head.last)
        begin
            count_reg <= 16'd0;
            hw_reg    <= 4'd0;
            tl_reg    <= 16'd0;
            hf_reg    <= 1'b0;
            kc_reg    <= 16'd0;
            id_reg    <= 16'd0;
            seq_reg   <= 16'd0;
            csum_reg  <= 16'd0;
            pend_reg  <= 8'd0;
        end
        else
        begin
            count_reg <= count_next;
            hw_reg    <= hw_next;
            tl_reg    <= tl_next;
            hf_reg    <= hf_next;
            kc_reg    <= kc_next;
            id_reg    <= id_next;
            seq_reg   <= seq_next;
            csum_reg  <= csum_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            b_last_reg     <= head.last;
            b_stamp_reg    <= chk_stamp;
            b_fill_reg     <= chk_fill;
            b_byte_reg     <= b;
            b_sel_reg      <= p[2:0];
            b_bad_reg      <= hf_next || cc != {1'b0, tl_next} || cc < 17'd20
                              || icmp_len < 17'd2;
            b_short_reg    <= icmp_len < 17'd24;
            b_csum_ok_reg  <= (csum_f == 16'hFFFF);
            b_has_kind_reg <= (icmp_len != 17'd0);
            b_has_seq_reg  <= (icmp_len >= 17'd8);
            b_kc_reg       <= kc_next;
            b_id_reg       <= id_next;
            b_seq_reg      <= seq_next;
        end
    end

    assign stamp_byte = 8'(ram_rdata >> {b_sel_reg, 3'b000});
    assign mismatch   = (b_stamp_reg && b_byte_reg != stamp_byte)
                        || (b_fill_reg && b_byte_reg != FILL_BYTE);
    assign pf_all     = pf_reg || mismatch;
    assign load_out   = b_valid_reg && b_last_reg && b_advance;

    always_comb
    begin
        if (b_bad_reg)
        begin
            verdict = VERDICT_INVALID;
        end
        else if (b_kc_reg[15:8] == TYPE_ECHO_REQUEST)
        begin
            verdict = VERDICT_OWN_REQ;
        end
        else if (b_kc_reg[15:8] != TYPE_ECHO_REPLY || b_kc_reg[7:0] != 8'd0)
        begin
            verdict = VERDICT_OTHER;
        end
        else if (b_short_reg || b_id_reg != expected_ident || b_seq_reg > highest_sequence
                 || pf_all || !b_csum_ok_reg)
        begin
            verdict = VERDICT_INVALID;
        end
        else
        begin
            verdict = VERDICT_VALID;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= {6'd0,
                             b_has_seq_reg ? b_seq_reg : 16'd0,
                             b_has_kind_reg ? b_kc_reg[15:8] : 8'd0,
                             verdict};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            pf_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_take)
            begin
                b_valid_reg <= is_byte;
            end
            if (b_valid_reg && b_advance)
            begin
                pf_reg <= b_last_reg ? 1'b0 : pf_all;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/icmp_echo_reply_checker_core.sv
// Checks received IPv4 ICMP packets fed one byte per transaction on s_axis (tlast on the
// final byte) and returns one verdict transaction on m_axis per packet. A transaction with
// tuser set instead writes one 64-bit send-stamp word into the stamp table. Sustained rate
// is one transaction per clock; m_axis_tvalid rises once the last byte has passed the
// input queue, then the header/checksum stage that starts the stamp read, then the
// stamp-compare stage that loads the output register. Only m_axis backpressure stalls it.
// The stamp table is a 128 x 64 single-port RAM with registered read; its entries are
// undefined until written, so every sequence checked must have its stamp loaded first.
module icmp_echo_reply_checker_core
    import icmp_erc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // data_byte[7:0], stamp_slot[13:8], stamp_half[14], stamp_word[78:15], zero[79]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type[0]
    input  logic [0:0]             s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // verdict[1:0], icmp_kind[9:2], echo_sequence[25:10], zero[31:26]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_wdata
);

    logic [15:0] ident_reg;
    logic [15:0] highest_reg;
    logic        head_valid;
    item_t       head;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg   <= 16'd0;
            highest_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDENT:   ident_reg   <= cfg_wdata;
                CFG_HIGHEST: highest_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    icmp_erc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_user    (s_axis_tuser[0]),
        .in_last    (s_axis_tlast),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    icmp_erc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (head_valid),
        .head             (head),
        .pop              (pop),
        .expected_ident   (ident_reg),
        .highest_sequence (highest_reg),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_data         (m_axis_tdata)
    );

endmodule

### design/icmp_erc_checker.sv
module icmp_erc_checker
    import icmp_erc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("verdict dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("verdict changed while stalled");

    a_valid_is_reply: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == VERDICT_VALID
        |-> m_axis_tdata[9:2] == TYPE_ECHO_REPLY)
        else $error("valid verdict on non-reply type");

    a_own_is_request: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == VERDICT_OWN_REQ
        |-> m_axis_tdata[9:2] == TYPE_ECHO_REQUEST)
        else $error("own-request verdict on non-request type");

endmodule

bind icmp_echo_reply_checker_core icmp_erc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
